@@ hw/rtl/mlp_pkg.sv @@
// Shared types, codes and helpers for the two-layer perceptron block.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mlp_pkg;

  localparam int FRAC_BITS = 24;
  localparam int IDX_W     = 7;

  localparam logic [2:0] CMD_LOAD_IN  = 3'd0;
  localparam logic [2:0] CMD_LOAD_TGT = 3'd1;
  localparam logic [2:0] CMD_WRITE    = 3'd2;
  localparam logic [2:0] CMD_INFER    = 3'd3;
  localparam logic [2:0] CMD_TRAIN    = 3'd4;

  localparam logic [1:0] SEL_HID_W = 2'd0;
  localparam logic [1:0] SEL_HID_B = 2'd1;
  localparam logic [1:0] SEL_OUT_W = 2'd2;
  localparam logic [1:0] SEL_OUT_B = 2'd3;

  typedef enum logic [1:0] {MA_P, MA_R, MA_D} mul_a_e;
  typedef enum logic {MB_S, MB_LR} mul_b_e;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_CLR, ACC_ADD} acc_op_e;
  typedef enum logic [1:0] {R_HOLD, R_LOAD, R_GATE} r_op_e;
  typedef enum logic [1:0] {PW_ITEM, PW_ZERO, PW_UPD} p_src_e;
  typedef enum logic [1:0] {SW_ITEM, SW_RELU, SW_SAT, SW_ERR} s_src_e;

  typedef struct packed {
    logic    p_rd;
    logic    p_we;
    p_src_e  p_src;
    logic    s_rd;
    logic    s_we;
    s_src_e  s_src;
    logic    mul_en;
    mul_a_e  mul_a;
    mul_b_e  mul_b;
    logic    d_en;
    acc_op_e acc_op;
    r_op_e   r_op;
    logic    out_en;
    logic    out_kind;
    logic [3:0] out_idx;
    logic    out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mlp_dp.sv @@
// Datapath: parameter and scratch memories, one multiplier, accumulator,
// saturation and the result word register. Depends on mlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlp_dp #(
  parameter int P_DEPTH = 212,
  parameter int S_DEPTH = 48,
  parameter int PA_W    = 8,
  parameter int SA_W    = 6
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  mlp_pkg::dp_cmd_t     cmd_i,
  input  wire  [PA_W-1:0]      p_raddr_i,
  input  wire  [PA_W-1:0]      p_waddr_i,
  input  wire  [SA_W-1:0]      s_raddr_i,
  input  wire  [SA_W-1:0]      s_waddr_i,
  input  wire  signed [31:0]   item_value_i,
  input  wire  [23:0]          learn_rate_i,
  output mlp_pkg::dp_sts_t     sts_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic                 result_kind_o,
  output logic [3:0]           out_index_o,
  output logic signed [31:0]   q_value_o,
  output logic                 last_flag_o
);
  import mlp_pkg::*;

  logic signed [31:0] pmem_q [P_DEPTH];
  logic signed [31:0] smem_q [S_DEPTH];
  logic signed [31:0] prd_q, srd_q, r_q, d_q;
  logic signed [63:0] prod_q, acc_q;
  logic signed [31:0] ma;
  logic signed [32:0] mb;
  logic signed [64:0] prod_w;
  logic signed [63:0] sh_w;
  logic signed [31:0] acc_sat, upd_w, err_w, p_wdata, s_wdata;
  logic               out_valid_q;

  assign sh_w    = prod_q >>> FRAC_BITS;
  assign acc_sat = sat32(acc_q);
  assign upd_w   = sat32({{32{prd_q[31]}}, prd_q} + sh_w);
  assign err_w   = sat32({{32{srd_q[31]}}, srd_q} - {{32{acc_sat[31]}}, acc_sat});

  always_comb begin
    case (cmd_i.mul_a)
      MA_R:    ma = r_q;
      MA_D:    ma = d_q;
      default: ma = prd_q;
    endcase
    if (cmd_i.mul_b == MB_LR) mb = {9'd0, learn_rate_i};
    else mb = {srd_q[31], srd_q};
    prod_w = ma * mb;
  end

  always_comb begin
    case (cmd_i.p_src)
      PW_ZERO: p_wdata = '0;
      PW_UPD:  p_wdata = upd_w;
      default: p_wdata = item_value_i;
    endcase
    case (cmd_i.s_src)
      SW_RELU: s_wdata = (acc_sat > 0) ? acc_sat : '0;
      SW_SAT:  s_wdata = acc_sat;
      SW_ERR:  s_wdata = err_w;
      default: s_wdata = item_value_i;
    endcase
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.p_we) pmem_q[p_waddr_i] <= p_wdata;
    if (cmd_i.p_rd) prd_q <= pmem_q[p_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.s_we) smem_q[s_waddr_i] <= s_wdata;
    if (cmd_i.s_rd) srd_q <= smem_q[s_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= prod_w[63:0];
    if (cmd_i.d_en) d_q <= sat32(sh_w);
    case (cmd_i.acc_op)
      ACC_LOAD: acc_q <= {{32{prd_q[31]}}, prd_q};
      ACC_CLR:  acc_q <= '0;
      ACC_ADD:  acc_q <= acc_q + sh_w;
      default:  acc_q <= acc_q;
    endcase
    case (cmd_i.r_op)
      R_LOAD:  r_q <= srd_q;
      R_GATE:  r_q <= (srd_q > 0) ? r_q : '0;
      default: r_q <= r_q;
    endcase
  end

  // Result word register: load on command, drop when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_en) begin
      result_kind_o <= cmd_i.out_kind;
      out_index_o   <= cmd_i.out_idx;
      q_value_o     <= cmd_i.out_kind ? 32'sd0 : acc_sat;
      last_flag_o   <= cmd_i.out_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_busy = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/mlp_ctrl.sv @@
// Controller: sequences the clearing sweep, item handling and the layer passes.
// Drives memory addresses and datapath commands. Depends on mlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlp_ctrl #(
  parameter int N_IN    = 8,
  parameter int N_HID   = 16,
  parameter int N_OUT   = 4,
  parameter int P_DEPTH = 212,
  parameter int S_DEPTH = 48,
  parameter int PA_W    = 8,
  parameter int SA_W    = 6
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [2:0]        cmd_i,
  input  wire  [1:0]        layer_sel_i,
  input  wire  [5:0]        row_index_i,
  input  wire  [5:0]        col_index_i,
  input  mlp_pkg::dp_sts_t  sts_i,
  output mlp_pkg::dp_cmd_t  cmd_o,
  output logic [PA_W-1:0]   p_raddr_o,
  output logic [PA_W-1:0]   p_waddr_o,
  output logic [SA_W-1:0]   s_raddr_o,
  output logic [SA_W-1:0]   s_waddr_o
);
  import mlp_pkg::*;

  localparam int HW_B   = 0;
  localparam int HB_B   = N_HID * N_IN;
  localparam int OW_B   = HB_B + N_HID;
  localparam int OB_B   = OW_B + N_OUT * N_HID;
  localparam int IN_B   = 0;
  localparam int TG_B   = N_IN;
  localparam int ACT_B  = TG_B + N_OUT;
  localparam int HE_B   = ACT_B + N_HID;
  localparam int OE_B   = HE_B + N_HID;
  localparam int S_LAST = S_DEPTH - 1;

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_RS_RD   = 4'd2;
  localparam logic [3:0] ST_RS_LD   = 4'd3;
  localparam logic [3:0] ST_RS_RD2  = 4'd4;
  localparam logic [3:0] ST_RS_GATE = 4'd5;
  localparam logic [3:0] ST_E_RD    = 4'd6;
  localparam logic [3:0] ST_E_MUL   = 4'd7;
  localparam logic [3:0] ST_E_D     = 4'd8;
  localparam logic [3:0] ST_E_MUL2  = 4'd9;
  localparam logic [3:0] ST_E_FIN   = 4'd10;
  localparam logic [3:0] ST_RE_RD   = 4'd11;
  localparam logic [3:0] ST_RE_MUL  = 4'd12;
  localparam logic [3:0] ST_RE_FIN  = 4'd13;
  localparam logic [3:0] ST_DONE    = 4'd14;

  localparam logic [2:0] PS_HFWD = 3'd0;
  localparam logic [2:0] PS_OFWD = 3'd1;
  localparam logic [2:0] PS_HERR = 3'd2;
  localparam logic [2:0] PS_OUPD = 3'd3;
  localparam logic [2:0] PS_HUPD = 3'd4;

  logic [3:0]       state_q, state_d;
  logic [2:0]       pass_q, pass_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d;
  logic             train_q, train_d;
  logic [PA_W-1:0]  clr_q, clr_d;
  logic             accept, upd_pass, last_row, last_col;
  int               rows_n, cols_n, ii, jj, row_i, col_i;
  logic [PA_W-1:0]  elem_pa, bias_pa;
  logic [SA_W-1:0]  elem_sa;
  logic [2:0]       next_pass;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign upd_pass = (pass_q == PS_OUPD) || (pass_q == PS_HUPD);
  assign ii       = int'(i_q);
  assign jj       = int'(j_q);
  assign row_i    = int'(row_index_i);
  assign col_i    = int'(col_index_i);

  always_comb begin
    rows_n    = N_HID;
    cols_n    = N_IN;
    elem_pa   = PA_W'(HW_B + ii * N_IN + jj);
    elem_sa   = SA_W'(IN_B + jj);
    bias_pa   = PA_W'(HB_B + ii);
    next_pass = PS_OFWD;
    unique case (pass_q)
      PS_OFWD: begin
        rows_n    = N_OUT;
        cols_n    = N_HID;
        elem_pa   = PA_W'(OW_B + ii * N_HID + jj);
        elem_sa   = SA_W'(ACT_B + jj);
        bias_pa   = PA_W'(OB_B + ii);
        next_pass = PS_HERR;
      end
      PS_HERR: begin
        cols_n    = N_OUT;
        elem_pa   = PA_W'(OW_B + jj * N_HID + ii);
        elem_sa   = SA_W'(OE_B + jj);
        next_pass = PS_OUPD;
      end
      PS_OUPD: begin
        rows_n    = N_OUT;
        cols_n    = N_HID;
        elem_pa   = PA_W'(OW_B + ii * N_HID + jj);
        elem_sa   = SA_W'(ACT_B + jj);
        bias_pa   = PA_W'(OB_B + ii);
        next_pass = PS_HUPD;
      end
      default: begin
        next_pass = (pass_q == PS_HUPD) ? PS_HFWD : PS_OFWD;
      end
    endcase
  end

  assign last_row = (ii == rows_n - 1);
  assign last_col = (jj == cols_n - 1);

  always_comb begin
    cmd_o     = '0;
    p_raddr_o = elem_pa;
    p_waddr_o = elem_pa;
    s_raddr_o = elem_sa;
    s_waddr_o = elem_sa;
    state_d   = state_q;
    pass_d    = pass_q;
    i_d       = i_q;
    j_d       = j_q;
    train_d   = train_q;
    clr_d     = clr_q;

    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.p_we  = 1'b1;
        cmd_o.p_src = PW_ZERO;
        p_waddr_o   = clr_q;
        if (int'(clr_q) == P_DEPTH - 1) state_d = ST_IDLE;
        else clr_d = clr_q + 1'b1;
      end

      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CMD_LOAD_IN: begin
              cmd_o.s_we = (col_i < N_IN);
              s_waddr_o  = SA_W'(IN_B + col_i);
            end
            CMD_LOAD_TGT: begin
              cmd_o.s_we = (col_i < N_OUT);
              s_waddr_o  = SA_W'(TG_B + col_i);
            end
            CMD_WRITE: begin
              unique case (layer_sel_i)
                SEL_HID_W: begin
                  cmd_o.p_we = (row_i < N_HID) && (col_i < N_IN);
                  p_waddr_o  = PA_W'(HW_B + row_i * N_IN + col_i);
                end
                SEL_HID_B: begin
                  cmd_o.p_we = (row_i < N_HID);
                  p_waddr_o  = PA_W'(HB_B + row_i);
                end
                SEL_OUT_W: begin
                  cmd_o.p_we = (row_i < N_OUT) && (col_i < N_HID);
                  p_waddr_o  = PA_W'(OW_B + row_i * N_HID + col_i);
                end
                default: begin
                  cmd_o.p_we = (row_i < N_OUT);
                  p_waddr_o  = PA_W'(OB_B + row_i);
                end
              endcase
            end
            CMD_INFER, CMD_TRAIN: begin
              train_d = (cmd_i == CMD_TRAIN);
              pass_d  = PS_HFWD;
              i_d     = '0;
              j_d     = '0;
              state_d = ST_RS_RD;
            end
            default: ;
          endcase
        end
      end

      ST_RS_RD: begin
        p_raddr_o = bias_pa;
        if (pass_q == PS_OUPD) begin
          cmd_o.s_rd = 1'b1;
          s_raddr_o  = SA_W'(OE_B + ii);
        end else if (pass_q == PS_HUPD) begin
          cmd_o.s_rd = 1'b1;
          s_raddr_o  = SA_W'(HE_B + ii);
        end else begin
          cmd_o.p_rd = 1'b1;
        end
        state_d = ST_RS_LD;
      end

      ST_RS_LD: begin
        if (upd_pass) cmd_o.r_op = R_LOAD;
        else if (pass_q == PS_HERR) cmd_o.acc_op = ACC_CLR;
        else cmd_o.acc_op = ACC_LOAD;
        j_d     = '0;
        state_d = (pass_q == PS_HUPD) ? ST_RS_RD2 : ST_E_RD;
      end

      ST_RS_RD2: begin
        cmd_o.s_rd = 1'b1;
        s_raddr_o  = SA_W'(ACT_B + ii);
        state_d    = ST_RS_GATE;
      end

      ST_RS_GATE: begin
        cmd_o.r_op = R_GATE;
        state_d    = ST_E_RD;
      end

      ST_E_RD: begin
        cmd_o.p_rd = 1'b1;
        cmd_o.s_rd = 1'b1;
        state_d    = ST_E_MUL;
      end

      ST_E_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_b  = MB_S;
        cmd_o.mul_a  = upd_pass ? MA_R : MA_P;
        state_d      = upd_pass ? ST_E_D : ST_E_FIN;
      end

      ST_E_D: begin
        cmd_o.d_en = 1'b1;
        state_d    = ST_E_MUL2;
      end

      ST_E_MUL2: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_a  = MA_D;
        cmd_o.mul_b  = MB_LR;
        state_d      = ST_E_FIN;
      end

      ST_E_FIN: begin
        if (upd_pass) begin
          cmd_o.p_we  = 1'b1;
          cmd_o.p_src = PW_UPD;
        end else begin
          cmd_o.acc_op = ACC_ADD;
        end
        if (last_col) begin
          j_d = '0;
          if (upd_pass || (pass_q == PS_OFWD && train_q)) state_d = ST_RE_RD;
          else state_d = ST_RE_FIN;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_E_RD;
        end
      end

      ST_RE_RD: begin
        p_raddr_o = bias_pa;
        s_raddr_o = SA_W'(TG_B + ii);
        if (upd_pass) begin
          cmd_o.p_rd = 1'b1;
          state_d    = ST_RE_MUL;
        end else begin
          cmd_o.s_rd = 1'b1;
          state_d    = ST_RE_FIN;
        end
      end

      ST_RE_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_a  = MA_R;
        cmd_o.mul_b  = MB_LR;
        state_d      = ST_RE_FIN;
      end

      ST_RE_FIN: begin
        p_waddr_o = bias_pa;
        if (!(pass_q == PS_OFWD && !train_q && sts_i.out_busy)) begin
          unique case (pass_q)
            PS_HFWD: begin
              cmd_o.s_we  = 1'b1;
              cmd_o.s_src = SW_RELU;
              s_waddr_o   = SA_W'(ACT_B + ii);
            end
            PS_HERR: begin
              cmd_o.s_we  = 1'b1;
              cmd_o.s_src = SW_SAT;
              s_waddr_o   = SA_W'(HE_B + ii);
            end
            PS_OFWD: begin
              if (train_q) begin
                cmd_o.s_we  = 1'b1;
                cmd_o.s_src = SW_ERR;
                s_waddr_o   = SA_W'(OE_B + ii);
              end else begin
                cmd_o.out_en   = 1'b1;
                cmd_o.out_idx  = i_q[3:0];
                cmd_o.out_last = last_row;
              end
            end
            default: begin
              cmd_o.p_we  = 1'b1;
              cmd_o.p_src = PW_UPD;
            end
          endcase
          if (last_row) begin
            i_d    = '0;
            pass_d = next_pass;
            if (pass_q == PS_OFWD && !train_q) state_d = ST_IDLE;
            else if (pass_q == PS_HUPD) state_d = ST_DONE;
            else if (next_pass == PS_HERR) state_d = ST_RS_LD;
            else state_d = ST_RS_RD;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = (pass_q == PS_HERR) ? ST_RS_LD : ST_RS_RD;
          end
        end
      end

      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_en   = 1'b1;
          cmd_o.out_kind = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (S_LAST < 0) s_raddr_o = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      pass_q  <= PS_HFWD;
      i_q     <= '0;
      j_q     <= '0;
      train_q <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      i_q     <= i_d;
      j_q     <= j_d;
      train_q <= train_d;
      clr_q   <= clr_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mlp_relu_infer_and_sgd_train.sv @@
// Top level of the two-layer ReLU perceptron with SGD training.
// Instantiates mlp_ctrl and mlp_dp and holds the learning-rate register; uses mlp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Two-layer perceptron: a ReLU hidden layer feeding a linear output layer, all
// values signed Q8.24, learning rate unsigned Q0.24 (APB register 0, reset
// 16777). Input words load an input or target element, write one weight or
// bias, run inference (N_OUT result words, the last one flagged) or run one
// SGD step (one "done" word). Each word is taken only when the block is idle.
// All work goes through one 32x33 multiplier, one accumulator and parameter
// and scratch memories with one write port and one registered read port each,
// so cost is set by that multiply loop. After reset the parameter memory is
// swept to zero, one entry a cycle, while input is stalled; configuration
// writes are taken throughout.
module mlp_relu_infer_and_sgd_train #(
  parameter int N_IN  = 8,
  parameter int N_HID = 16,
  parameter int N_OUT = 4
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [2:0]         cmd_i,
  input  wire  [1:0]         layer_sel_i,
  input  wire  [5:0]         row_index_i,
  input  wire  [5:0]         col_index_i,
  input  wire  signed [31:0] data_value_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic               result_kind_o,
  output logic [3:0]         out_index_o,
  output logic signed [31:0] q_value_o,
  output logic               last_flag_o,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [2:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mlp_pkg::*;

  // Memory layout: hidden weights, hidden biases, output weights, output
  // biases in the parameter memory; inputs, targets, activations and errors
  // in the scratch memory.
  localparam int P_DEPTH = N_HID * N_IN + N_HID + N_OUT * N_HID + N_OUT;
  localparam int S_DEPTH = N_IN + N_OUT + 2 * N_HID + N_OUT;
  localparam int PA_W    = $clog2(P_DEPTH);
  localparam int SA_W    = $clog2(S_DEPTH);
  localparam logic [2:0] ADDR_LR = 3'd0;
  localparam logic [23:0] LR_RESET = 24'd16777;

  logic [23:0]      lr_q;
  dp_cmd_t          dp_cmd;
  dp_sts_t          dp_sts;
  logic [PA_W-1:0]  p_raddr, p_waddr;
  logic [SA_W-1:0]  s_raddr, s_waddr;

  // Configuration port: always ready, write on the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LR) ? {8'd0, lr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= LR_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_LR)) begin
      lr_q <= pwdata[23:0];
    end
  end

  mlp_ctrl #(
    .N_IN    (N_IN),
    .N_HID   (N_HID),
    .N_OUT   (N_OUT),
    .P_DEPTH (P_DEPTH),
    .S_DEPTH (S_DEPTH),
    .PA_W    (PA_W),
    .SA_W    (SA_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .layer_sel_i (layer_sel_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd),
    .p_raddr_o   (p_raddr),
    .p_waddr_o   (p_waddr),
    .s_raddr_o   (s_raddr),
    .s_waddr_o   (s_waddr)
  );

  mlp_dp #(
    .P_DEPTH (P_DEPTH),
    .S_DEPTH (S_DEPTH),
    .PA_W    (PA_W),
    .SA_W    (SA_W)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .p_raddr_i     (p_raddr),
    .p_waddr_i     (p_waddr),
    .s_raddr_i     (s_raddr),
    .s_waddr_i     (s_waddr),
    .item_value_i  (data_value_i),
    .learn_rate_i  (lr_q),
    .sts_o         (dp_sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .out_index_o   (out_index_o),
    .q_value_o     (q_value_o),
    .last_flag_o   (last_flag_o)
  );

endmodule

`default_nettype wire
